>>> hdl/hdu8n1_pkg.sv
// ----------------------------------------------------------------------------
// hdu8n1_pkg: shared types and constants for the half-duplex 8N1 UART
// Holds the line mode codes, the frame constants and the result layout.
// ----------------------------------------------------------------------------
package hdu8n1_pkg;

    // Line mode, also shown on the busy state output.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [7:0] {
        REG_BIT_TICKS      = 8'd0,
        REG_HALF_BIT_TICKS = 8'd1
    } t_reg_index;

    // Samples in one received frame: start, eight data, stop.
    localparam logic [3:0] FrameBits = 4'd10;
    // Bits left to shift out after the start bit is driven.
    localparam logic [3:0] TxBitsAfterStart = 4'd9;

    // Reset values of the timing registers.
    localparam logic [15:0] BitTicksReset     = 16'd104;
    localparam logic [15:0] HalfBitTicksReset = 16'd52;

    // One result item, as it waits in the output register.
    typedef struct packed {
        logic       tx_line;
        logic       send_accepted;
        logic       byte_valid;
        logic [7:0] received_byte;
        t_mode      busy_state;
    } t_result;

endpackage

>>> hdl/half_duplex_uart_8n1.sv
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1: tick-timed half-duplex 8N1 UART
// Receives and transmits 8N1 frames, one at a time, from per-tick inputs.
// ----------------------------------------------------------------------------
// Each accepted input transfer is one tick of the bit timer and produces one
// result transfer. The block takes one tick per clock cycle: the full state
// update is a single pass of logic from the state registers into a result
// register, so the input is stalled only while two results (the output
// register and its skid stage) wait to be taken. The user is to write timing
// registers through the configuration port while the block is idle; it does
// not enforce it. Zero acts as one; values over the counter range saturate.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1 #(
    parameter int TICK_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_rx_line,
    input  logic        i_send_request,
    input  logic [7:0]  i_send_byte,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_line,
    output logic        o_send_accepted,
    output logic        o_byte_valid,
    output logic [7:0]  o_received_byte,
    output logic [1:0]  o_busy_state,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [32:0] TickMax = (33'd1 << TICK_WIDTH) - 33'd1;

    // Clamp a timing register value into the counter range.
    function automatic logic [TICK_WIDTH-1:0] sat_ticks(input logic [15:0] value);
        logic [32:0] wide;
        wide = {17'd0, value};
        if (wide == 33'd0) begin
            wide = 33'd1;
        end
        if (wide > TickMax) begin
            wide = TickMax;
        end
        return wide[TICK_WIDTH-1:0];
    endfunction

    // Timing registers, held already clamped.
    logic [TICK_WIDTH-1:0] r_bit_ticks;
    logic [TICK_WIDTH-1:0] r_half_ticks;

    // Line state.
    hdu8n1_pkg::t_mode     r_mode, n_mode;
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic [3:0]            r_bits, n_bits;
    logic [9:0]            r_shift, n_shift;
    logic                  r_prev_rx, n_prev_rx;
    logic                  r_tx, n_tx;
    logic [7:0]            r_last, n_last;

    // Output register and skid stage.
    hdu8n1_pkg::t_result r_out, r_skid, n_result;
    logic                r_out_valid, r_skid_valid;

    logic                  in_xfer;
    logic                  out_xfer;
    logic [TICK_WIDTH-1:0] tick_dec;
    logic [9:0]            rx_shift;
    logic [3:0]            bits_dec;
    logic                  accepted;
    logic                  valid_byte;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_xfer     = i_in_valid && !r_skid_valid;
    assign out_xfer    = r_out_valid && !i_out_stall;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks  <= sat_ticks(hdu8n1_pkg::BitTicksReset);
            r_half_ticks <= sat_ticks(hdu8n1_pkg::HalfBitTicksReset);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == hdu8n1_pkg::REG_BIT_TICKS) begin
                r_bit_ticks <= sat_ticks(i_cfg_data);
            end else if (i_cfg_index == hdu8n1_pkg::REG_HALF_BIT_TICKS) begin
                r_half_ticks <= sat_ticks(i_cfg_data);
            end
        end
    end

    // Next line state for one tick.
    always_comb begin
        n_mode     = r_mode;
        n_tick     = r_tick;
        n_bits     = r_bits;
        n_shift    = r_shift;
        n_tx       = r_tx;
        n_last     = r_last;
        n_prev_rx  = i_rx_line;
        accepted   = 1'b0;
        valid_byte = 1'b0;
        tick_dec   = r_tick - {{(TICK_WIDTH-1){1'b0}}, 1'b1};
        bits_dec   = r_bits - 4'd1;
        rx_shift   = {i_rx_line, r_shift[9:1]};
        case (r_mode)
            hdu8n1_pkg::MODE_RX: begin
                n_tick = tick_dec;
                if (tick_dec == '0) begin
                    n_shift = rx_shift;
                    n_bits  = bits_dec;
                    n_tick  = r_bit_ticks;
                    if (bits_dec == 4'd0) begin
                        n_mode = hdu8n1_pkg::MODE_IDLE;
                        // Good frame: start bit low, stop bit high.
                        if (rx_shift[9] && !rx_shift[0]) begin
                            n_last     = rx_shift[8:1];
                            valid_byte = 1'b1;
                        end
                    end
                end
            end
            hdu8n1_pkg::MODE_TX: begin
                n_tick = tick_dec;
                if (tick_dec == '0) begin
                    if (r_bits == 4'd0) begin
                        n_mode = hdu8n1_pkg::MODE_IDLE;
                        n_tx   = 1'b1;
                    end else begin
                        n_tx    = r_shift[0];
                        n_shift = {1'b0, r_shift[9:1]};
                        n_bits  = bits_dec;
                        n_tick  = r_bit_ticks;
                    end
                end
            end
            default: begin
                n_mode = hdu8n1_pkg::MODE_IDLE;
                // A falling edge wins over a pending send request.
                if (r_prev_rx && !i_rx_line) begin
                    n_mode  = hdu8n1_pkg::MODE_RX;
                    n_tick  = r_half_ticks;
                    n_bits  = hdu8n1_pkg::FrameBits;
                    n_shift = '0;
                end else if (i_send_request) begin
                    n_mode   = hdu8n1_pkg::MODE_TX;
                    accepted = 1'b1;
                    n_tx     = 1'b0;
                    n_shift  = {2'b01, i_send_byte};
                    n_bits   = hdu8n1_pkg::TxBitsAfterStart;
                    n_tick   = r_bit_ticks;
                end
            end
        endcase

        n_result.tx_line       = n_tx;
        n_result.send_accepted = accepted;
        n_result.byte_valid    = valid_byte;
        n_result.received_byte = n_last;
        n_result.busy_state    = n_mode;
    end

    // Line state registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= hdu8n1_pkg::MODE_IDLE;
            r_tick    <= '0;
            r_bits    <= 4'd0;
            r_shift   <= 10'd0;
            r_prev_rx <= 1'b1;
            r_tx      <= 1'b1;
            r_last    <= 8'd0;
        end else if (in_xfer) begin
            r_mode    <= n_mode;
            r_tick    <= n_tick;
            r_bits    <= n_bits;
            r_shift   <= n_shift;
            r_prev_rx <= n_prev_rx;
            r_tx      <= n_tx;
            r_last    <= n_last;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out       <= n_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_line       = r_out.tx_line;
    assign o_send_accepted = r_out.send_accepted;
    assign o_byte_valid    = r_out.byte_valid;
    assign o_received_byte = r_out.received_byte;
    assign o_busy_state    = r_out.busy_state;

endmodule

>>> hdl/hdu8n1_checker.sv
// ----------------------------------------------------------------------------
// hdu8n1_checker: port-level assertions for the half-duplex 8N1 UART
// Watches the result channel of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module hdu8n1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_tx_line,
    input logic        o_send_accepted,
    input logic        o_byte_valid,
    input logic [7:0]  o_received_byte,
    input logic [1:0]  o_busy_state
);

    logic out_xfer;
    assign out_xfer = o_out_valid && !i_out_stall;

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable({o_tx_line, o_send_accepted, o_byte_valid,
                        o_received_byte, o_busy_state}))
        else $error("stalled result changed");

    // A completed byte returns the line to idle.
    a_rx_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_byte_valid |-> o_busy_state == hdu8n1_pkg::MODE_IDLE)
        else $error("byte delivered outside idle");

    // A taken send request starts a transmit with the start bit.
    a_tx_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_send_accepted |->
            o_busy_state == hdu8n1_pkg::MODE_TX && !o_tx_line)
        else $error("send accepted without start bit");

    // The transmit line rests at mark whenever the block is not transmitting.
    a_idle_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_busy_state != hdu8n1_pkg::MODE_TX |-> o_tx_line)
        else $error("transmit line low outside a transmit");

    // A send is never accepted in the tick in which a byte completes.
    a_half_duplex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> !(o_send_accepted && o_byte_valid))
        else $error("send accepted while a byte completed");

endmodule

bind half_duplex_uart_8n1 hdu8n1_checker u_hdu8n1_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_tx_line       (o_tx_line),
    .o_send_accepted (o_send_accepted),
    .o_byte_valid    (o_byte_valid),
    .o_received_byte (o_received_byte),
    .o_busy_state    (o_busy_state)
);

>>> tb/half_duplex_uart_8n1_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1_checker: result checker for the half-duplex UART
// Watches the tick, result and configuration channels. It keeps its own
// copy of the line state, works out the result of every accepted tick and
// compares each result transfer with the oldest one still due.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_rx_line,
    input  logic                i_send_request,
    input  logic [7:0]          i_send_byte,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_tx_line,
    input  logic                i_send_accepted,
    input  logic                i_byte_valid,
    input  logic [7:0]          i_received_byte,
    input  logic [1:0]          i_busy_state,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output hdu8n1_pkg::t_mode   o_line_mode
);

    // Timing registers as last written.
    logic [15:0] period_reg;
    logic [15:0] half_reg;

    // Line state of the UART.
    hdu8n1_pkg::t_mode uart_mode;
    logic [15:0]       tick_left;
    logic [3:0]        bits_to_go;
    logic [9:0]        shift_reg;
    logic              rx_prev;
    logic              tx_pin;
    logic [7:0]        byte_held;

    // Results still owed by the block, oldest first.
    hdu8n1_pkg::t_result line_results[$];
    int                  results_seen;
    int                  mismatches;

    assign o_fail_count = mismatches;

    // A zero period counts as one tick; a 16-bit counter holds every value.
    function automatic logic [15:0] load_period(input logic [15:0] value);
        return (value == 16'd0) ? 16'd1 : value;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("ERROR: result %0d %s got %0h expected %0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic store_reg(input logic [7:0] idx, input logic [15:0] value);
        if (idx == hdu8n1_pkg::REG_BIT_TICKS) begin
            period_reg = value;
        end else if (idx == hdu8n1_pkg::REG_HALF_BIT_TICKS) begin
            half_reg = value;
        end
    endtask

    // One tick of the line: receive sampling, transmit shifting or idle
    // edge and request detection.
    function automatic hdu8n1_pkg::t_result advance_line(input logic rx,
                                                         input logic req,
                                                         input logic [7:0] data);
        hdu8n1_pkg::t_result res;
        res.send_accepted = 1'b0;
        res.byte_valid    = 1'b0;
        case (uart_mode)
            hdu8n1_pkg::MODE_RX: begin
                tick_left = tick_left - 16'd1;
                if (tick_left == 16'd0) begin
                    shift_reg  = {rx, shift_reg[9:1]};
                    bits_to_go = bits_to_go - 4'd1;
                    tick_left  = load_period(period_reg);
                    if (bits_to_go == 4'd0) begin
                        uart_mode = hdu8n1_pkg::MODE_IDLE;
                        // Start sampled low and stop sampled high.
                        if (shift_reg[9] && !shift_reg[0]) begin
                            byte_held     = shift_reg[8:1];
                            res.byte_valid = 1'b1;
                        end
                    end
                end
            end
            hdu8n1_pkg::MODE_TX: begin
                tick_left = tick_left - 16'd1;
                if (tick_left == 16'd0) begin
                    if (bits_to_go == 4'd0) begin
                        uart_mode = hdu8n1_pkg::MODE_IDLE;
                        tx_pin    = 1'b1;
                    end else begin
                        tx_pin     = shift_reg[0];
                        shift_reg  = shift_reg >> 1;
                        bits_to_go = bits_to_go - 4'd1;
                        tick_left  = load_period(period_reg);
                    end
                end
            end
            default: begin
                // Reception wins over a request in the same tick.
                uart_mode = hdu8n1_pkg::MODE_IDLE;
                if (rx_prev && !rx) begin
                    uart_mode  = hdu8n1_pkg::MODE_RX;
                    tick_left  = load_period(half_reg);
                    bits_to_go = hdu8n1_pkg::FrameBits;
                    shift_reg  = '0;
                end else if (req) begin
                    // Start bit goes out now; data then stop remain.
                    uart_mode         = hdu8n1_pkg::MODE_TX;
                    res.send_accepted = 1'b1;
                    tx_pin            = 1'b0;
                    shift_reg         = {2'b01, data};
                    bits_to_go        = hdu8n1_pkg::TxBitsAfterStart;
                    tick_left         = load_period(period_reg);
                end
            end
        endcase
        rx_prev = rx;
        res.tx_line       = tx_pin;
        res.received_byte = byte_held;
        res.busy_state    = uart_mode;
        return res;
    endfunction

    // Follow all three channels at every clock edge.
    always @(posedge i_clk) begin : watch
        hdu8n1_pkg::t_result due;
        if (!i_rst_n) begin
            period_reg = hdu8n1_pkg::BitTicksReset;
            half_reg   = hdu8n1_pkg::HalfBitTicksReset;
            uart_mode  = hdu8n1_pkg::MODE_IDLE;
            tick_left  = '0;
            bits_to_go = '0;
            shift_reg  = '0;
            rx_prev    = 1'b1;
            tx_pin     = 1'b1;
            byte_held  = '0;
            line_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                store_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                line_results.push_back(advance_line(i_rx_line, i_send_request,
                                                    i_send_byte));
            if (i_out_valid && !i_out_stall) begin
                if (line_results.size() == 0) begin
                    flag_mismatch("transfer with nothing due", 8'h00, 8'h00);
                end else begin
                    due = line_results.pop_front();
                    if (i_tx_line !== due.tx_line)
                        flag_mismatch("tx_line", 8'(i_tx_line), 8'(due.tx_line));
                    if (i_send_accepted !== due.send_accepted)
                        flag_mismatch("send_accepted", 8'(i_send_accepted),
                                      8'(due.send_accepted));
                    if (i_byte_valid !== due.byte_valid)
                        flag_mismatch("byte_valid", 8'(i_byte_valid),
                                      8'(due.byte_valid));
                    if (i_received_byte !== due.received_byte)
                        flag_mismatch("received_byte", i_received_byte,
                                      due.received_byte);
                    if (i_busy_state !== due.busy_state)
                        flag_mismatch("busy_state", 8'(i_busy_state),
                                      8'(due.busy_state));
                end
                results_seen++;
            end
        end
        o_pending   <= line_results.size();
        o_line_mode <= uart_mode;
    end

endmodule

>>> tb/half_duplex_uart_8n1_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1_tb: testbench top for the half-duplex 8N1 UART
// Feeds ticks carrying receive frames, transmit requests and line noise
// under several bit timings, with random gaps and result back-pressure,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1_tb;

    localparam int         QuietLimit  = 5000;
    localparam int         IdlePercent = 37;
    // Indexes that name no register.
    localparam logic [7:0] RegStrayNext = 8'd2;
    localparam logic [7:0] RegStrayTop  = 8'hFF;

    // What the receive line does while a frame is transmitted.
    typedef enum int {
        TxLineHigh,
        TxLineLow,
        TxLineNoise
    } t_tx_rx;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_rx_line      = 1'b1;
    logic        i_send_request = 1'b0;
    logic [7:0]  i_send_byte    = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic        o_tx_line;
    logic        o_send_accepted;
    logic        o_byte_valid;
    logic [7:0]  o_received_byte;
    logic [1:0]  o_busy_state;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index    = 8'h00;
    logic [15:0] i_cfg_data     = 16'h0000;

    logic              calm = 1'b0;
    int                ticks_sent = 0;
    int                period_ticks = int'(hdu8n1_pkg::BitTicksReset);
    int                half_ticks = int'(hdu8n1_pkg::HalfBitTicksReset);
    int                quiet_cycles = 0;
    int                fail_count;
    int                pending;
    hdu8n1_pkg::t_mode line_mode;

    half_duplex_uart_8n1 u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_line       (i_rx_line),
        .i_send_request  (i_send_request),
        .i_send_byte     (i_send_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tx_line       (o_tx_line),
        .o_send_accepted (o_send_accepted),
        .o_byte_valid    (o_byte_valid),
        .o_received_byte (o_received_byte),
        .o_busy_state    (o_busy_state),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    half_duplex_uart_8n1_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_rx_line       (i_rx_line),
        .i_send_request  (i_send_request),
        .i_send_byte     (i_send_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_tx_line       (o_tx_line),
        .i_send_accepted (o_send_accepted),
        .i_byte_valid    (o_byte_valid),
        .i_received_byte (o_received_byte),
        .i_busy_state    (o_busy_state),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_line_mode     (line_mode)
    );

    // Clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result back-pressure, off during the calm stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IdlePercent);
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QuietLimit) begin
                $display("half_duplex_uart_8n1 test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // One tick transfer, after a random number of idle cycles.
    task automatic send_tick(input logic rx, input logic req, input logic [7:0] data);
        while (!calm && $urandom_range(99) < IdlePercent) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_rx_line      <= rx;
        i_send_request <= req;
        i_send_byte    <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ticks_sent++;
    endtask

    // Keep the line high until the UART is idle again; leaves the last
    // tick high so that a following low tick is a start edge.
    task automatic wait_line_idle();
        send_tick(1'b1, 1'b0, 8'h00);
        while (line_mode != hdu8n1_pkg::MODE_IDLE) send_tick(1'b1, 1'b0, 8'h00);
    endtask

    // Stop sending until every result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // New bit timing, written with the line idle and nothing in flight.
    task automatic retime(input logic [15:0] period_val, input logic [15:0] half_val,
                          input bit stray);
        wait_line_idle();
        drain();
        if (stray) begin
            write_reg(RegStrayNext, 16'h0003);
            write_reg(RegStrayTop, 16'hFFFF);
        end
        write_reg(hdu8n1_pkg::REG_BIT_TICKS, period_val);
        write_reg(hdu8n1_pkg::REG_HALF_BIT_TICKS, half_val);
        i_cfg_valid  <= 1'b0;
        period_ticks = (period_val == 16'd0) ? 1 : int'(period_val);
        half_ticks   = (half_val == 16'd0) ? 1 : int'(half_val);
    endtask

    // Receive frame, start edge first; bit k is on the line for the
    // period that ends at its sample point. bits[0] is start, bits[9] stop.
    task automatic rx_frame(input logic [9:0] bits, input logic req,
                            input logic [7:0] data);
        int         span;
        logic [3:0] k;
        span = half_ticks + 9 * period_ticks;
        send_tick(1'b0, req, data);
        for (int o = 1; o <= span; o++) begin
            k = (o <= half_ticks) ? 4'd0 :
                4'((o - half_ticks + period_ticks - 1) / period_ticks);
            send_tick(bits[k], req, data);
        end
    endtask

    // Hold a request until it is taken, then tick through the transmit.
    task automatic tx_frame(input logic [7:0] data, input t_tx_rx style);
        logic rx;
        while (line_mode != hdu8n1_pkg::MODE_TX) send_tick(1'b1, 1'b1, data);
        while (line_mode != hdu8n1_pkg::MODE_IDLE) begin
            case (style)
                TxLineHigh: rx = 1'b1;
                TxLineLow:  rx = 1'b0;
                default:    rx = 1'($urandom_range(1));
            endcase
            send_tick(rx, 1'b0, data);
        end
    endtask

    // Random mix of good and broken frames, transmits and noise.
    task automatic run_mix(input int budget);
        int          stop_at;
        int          pick;
        bit          hold;
        logic [7:0]  data;
        logic [9:0]  bits;
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at) begin
            pick = $urandom_range(99);
            data = 8'($urandom_range(255));
            if (pick < 40) begin
                // Good frame, now and then with a request waiting on it.
                hold = ($urandom_range(4) == 0);
                rx_frame({1'b1, data, 1'b0}, hold, data ^ 8'hA5);
                if (hold)
                    tx_frame(data ^ 8'hA5, t_tx_rx'($urandom_range(2)));
            end else if (pick < 55) begin
                bits = {1'b1, data, 1'b0};
                case ($urandom_range(2))
                    0: bits[0] = 1'b1;
                    1: bits[9] = 1'b0;
                    default: bits = {1'b0, data, 1'b1};
                endcase
                rx_frame(bits, 1'b0, 8'h00);
            end else if (pick < 85) begin
                tx_frame(data, t_tx_rx'($urandom_range(2)));
            end else if (pick < 95) begin
                repeat ($urandom_range(8, 1))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                              8'($urandom_range(255)));
            end else begin
                drain();
            end
            wait_line_idle();
        end
    endtask

    initial begin : stimulus
        logic [15:0] period_pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values on an idle line, then the shortest timing: one tick
        // per bit and a zero half bit that acts as one.
        send_tick(1'b1, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 8'h00);
        retime(16'd1, 16'd0, 1'b0);
        // Start edge and request in the same tick: the frame wins and the
        // request waits; the line is then held low through the transmit.
        rx_frame({1'b1, 8'h00, 1'b0}, 1'b1, 8'hFF);
        tx_frame(8'hFF, TxLineLow);

        retime(16'd2, 16'd1, 1'b0);
        run_mix(130);

        // Stray register indexes, then a stretch without any idling.
        calm <= 1'b1;
        retime(16'd4, 16'd2, 1'b1);
        run_mix(130);
        calm <= 1'b0;

        // First sample later than one bit period.
        retime(16'd5, 16'd7, 1'b0);
        run_mix(90);

        // Zero bit period acts as one.
        retime(16'd0, 16'd1, 1'b0);
        run_mix(70);

        period_pick = 16'($urandom_range(8, 3));
        retime(period_pick, 16'($urandom_range(period_pick, 1)), 1'b0);
        run_mix(130);

        // First sample many bit periods after the edge: one frame and one
        // transmit.
        retime(16'd2, 16'd30, 1'b0);
        rx_frame({1'b1, 8'($urandom_range(255)), 1'b0}, 1'b0, 8'h00);
        tx_frame(8'($urandom_range(255)), TxLineNoise);

        // Longest bit period, on an idle line only.
        retime(16'hFFFF, 16'd1, 1'b0);
        repeat (6) send_tick(1'b1, 1'b0, 8'h00);

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("half_duplex_uart_8n1 test passed");
        end else begin
            $display("half_duplex_uart_8n1 test failed");
        end
        $finish;
    end

endmodule

>>> half_duplex_uart_8n1.f
hdl/hdu8n1_pkg.sv
hdl/half_duplex_uart_8n1.sv
hdl/hdu8n1_checker.sv
tb/half_duplex_uart_8n1_checker.sv
tb/half_duplex_uart_8n1_tb.sv
